// ----- rtl/core/msitw_pkg.sv -----
// Shared constants for the multi-slot interval timer with watchdog.
package msitw_pkg;

    localparam int SLOTS       = 8;
    localparam int COUNT_WIDTH = 32;
    localparam int SLOT_IW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // watchdog count never passes limit + 1 (limit is 16 bits)
    localparam int WD_W        = 17;

    localparam int OP_W        = 3;
    localparam int SLOT_W      = 3;
    localparam int IVAL_W      = 32;
    localparam int STATUS_W    = 2;
    localparam int IDX_W       = 3;
    localparam int MASK_W      = 8;
    localparam int TICK_W      = 32;
    localparam int LIMIT_W     = 16;

    localparam int S_DATA_W    = 40;
    localparam int M_DATA_W    = 48;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
    localparam logic [OP_W-1:0] OP_REG   = 3'd1;
    localparam logic [OP_W-1:0] OP_UNREG = 3'd2;
    localparam logic [OP_W-1:0] OP_REARM = 3'd3;
    localparam logic [OP_W-1:0] OP_KICK  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOSLOT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_HALTED = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WD_ENABLE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WD_LIMIT  = 8'd1;

    localparam logic [LIMIT_W-1:0] WD_LIMIT_RST = 16'd1000;

    typedef logic [COUNT_WIDTH-1:0] count_t;

endpackage

// ----- rtl/core/multi_slot_interval_timer_watchdog_core.sv -----
// Top level: eight-slot interval timer with watchdog, one word in, one word out.
//
//  port group   dir   content
//  s_axis       in    command word: op, slot, interval
//  m_axis       out   result word: status, slot_index, expired_mask, watchdog_fired, tick_count
//  cfg          in    register write: index, data
//
//  One word per cycle unless m_ stalls: an input register, one pass of slot/watchdog logic, an output register.
//  m_tvalid comes from the output register, loaded as the input register advances; all eight slots update in parallel.
//  Reset (aresetn low, synchronous) frees all slots, clears watchdog, tick count and halt.
//  A stalled m_ side holds the result word and the input register backs up into s_tready.
module multi_slot_interval_timer_watchdog_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [2:0] op, [5:3] slot, [37:6] interval, [39:38] zero
    input  logic [msitw_pkg::S_DATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [1:0] status, [4:2] slot_index, [12:5] expired_mask, [13] watchdog_fired,
    // [45:14] tick_count, [47:46] zero
    output logic [msitw_pkg::M_DATA_W-1:0]     m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [msitw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [msitw_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int SLOTS = msitw_pkg::SLOTS;
    localparam int CW    = msitw_pkg::COUNT_WIDTH;

    // configuration
    logic                              wd_enable_reg;
    logic [msitw_pkg::LIMIT_W-1:0]     wd_limit_reg;

    // input register
    logic                              in_valid_reg;
    logic [msitw_pkg::OP_W-1:0]        in_op_reg;
    logic [msitw_pkg::SLOT_W-1:0]      in_slot_reg;
    logic [msitw_pkg::IVAL_W-1:0]      in_ival_reg;

    // block state
    logic                              active_reg [SLOTS];
    logic                              active_next [SLOTS];
    msitw_pkg::count_t                 ival_reg [SLOTS];
    msitw_pkg::count_t                 ival_next [SLOTS];
    msitw_pkg::count_t                 cnt_reg [SLOTS];
    msitw_pkg::count_t                 cnt_next [SLOTS];
    msitw_pkg::count_t                 cnt_inc [SLOTS];
    logic [msitw_pkg::WD_W-1:0]        wd_cnt_reg;
    logic [msitw_pkg::WD_W-1:0]        wd_cnt_next;
    logic [msitw_pkg::WD_W-1:0]        wd_inc;
    logic [msitw_pkg::TICK_W-1:0]      ticks_reg;
    logic [msitw_pkg::TICK_W-1:0]      ticks_next;
    logic                              halted_reg;
    logic                              halted_next;

    // result
    logic [msitw_pkg::STATUS_W-1:0]    res_status;
    logic [msitw_pkg::IDX_W-1:0]       res_idx;
    logic [msitw_pkg::MASK_W-1:0]      res_mask;
    logic                              res_fired;
    logic                              free_found;
    logic [msitw_pkg::SLOT_IW-1:0]     free_idx;

    logic                              out_valid_reg;
    logic [msitw_pkg::M_DATA_W-1:0]    out_data_reg;

    logic                              advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = aresetn && (!in_valid_reg || advance);
    assign cfg_ready = aresetn;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign wd_inc    = wd_cnt_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wd_enable_reg <= 1'b0;
            wd_limit_reg  <= msitw_pkg::WD_LIMIT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                msitw_pkg::CFG_WD_ENABLE: wd_enable_reg <= cfg_data[0];
                msitw_pkg::CFG_WD_LIMIT:  wd_limit_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg   <= s_tdata[2:0];
            in_slot_reg <= s_tdata[5:3];
            in_ival_reg <= s_tdata[37:6];
        end
    end

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        res_idx    = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!active_reg[i]) begin
                free_found = 1'b1;
                free_idx   = msitw_pkg::SLOT_IW'(i);
                res_idx    = msitw_pkg::IDX_W'(i);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            active_next[i] = active_reg[i];
            ival_next[i]   = ival_reg[i];
            cnt_next[i]    = cnt_reg[i];
            cnt_inc[i]     = cnt_reg[i] + 1'b1;
        end
        wd_cnt_next = wd_cnt_reg;
        ticks_next  = ticks_reg;
        halted_next = halted_reg;
        res_status  = msitw_pkg::ST_OK;
        res_mask    = '0;
        res_fired   = 1'b0;
        if (halted_reg) begin
            res_status = msitw_pkg::ST_HALTED;
        end else begin
            case (in_op_reg)
                msitw_pkg::OP_TICK: begin
                    if (wd_enable_reg) begin
                        wd_cnt_next = wd_inc;
                        if (wd_inc > {1'b0, wd_limit_reg}) begin
                            halted_next = 1'b1;
                            res_status  = msitw_pkg::ST_HALTED;
                            res_fired   = 1'b1;
                        end
                    end
                    if (!halted_next) begin
                        ticks_next = ticks_reg + 1'b1;
                        for (int i = 0; i < SLOTS; i++) begin
                            if (active_reg[i]) begin
                                if (cnt_inc[i] >= ival_reg[i]) begin
                                    cnt_next[i] = '0;
                                    if (i < msitw_pkg::MASK_W) begin
                                        res_mask[i] = 1'b1;
                                    end
                                end else begin
                                    cnt_next[i] = cnt_inc[i];
                                end
                            end
                        end
                    end
                end
                msitw_pkg::OP_REG: begin
                    if (free_found) begin
                        active_next[free_idx] = 1'b1;
                        ival_next[free_idx]   = CW'(in_ival_reg);
                        cnt_next[free_idx]    = '0;
                    end else begin
                        res_status = msitw_pkg::ST_NOSLOT;
                    end
                end
                msitw_pkg::OP_UNREG: begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (i < 8 && in_slot_reg == msitw_pkg::SLOT_W'(i)) begin
                            active_next[i] = 1'b0;
                        end
                    end
                end
                msitw_pkg::OP_REARM: begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (i < 8 && in_slot_reg == msitw_pkg::SLOT_W'(i) && active_reg[i]) begin
                            if (in_ival_reg == '0) begin
                                active_next[i] = 1'b0;
                            end else begin
                                ival_next[i] = CW'(in_ival_reg);
                            end
                        end
                    end
                end
                msitw_pkg::OP_KICK: begin
                    wd_cnt_next = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                active_reg[i] <= 1'b0;
            end
            wd_cnt_reg <= '0;
            ticks_reg  <= '0;
            halted_reg <= 1'b0;
        end else if (advance) begin
            for (int i = 0; i < SLOTS; i++) begin
                active_reg[i] <= active_next[i];
            end
            wd_cnt_reg <= wd_cnt_next;
            ticks_reg  <= ticks_next;
            halted_reg <= halted_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int i = 0; i < SLOTS; i++) begin
                ival_reg[i] <= ival_next[i];
                cnt_reg[i]  <= cnt_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {2'b00, ticks_next, res_fired, res_mask,
                (res_status == msitw_pkg::ST_OK && in_op_reg == msitw_pkg::OP_REG && !halted_reg)
                    ? res_idx : msitw_pkg::IDX_W'(0),
                res_status};
        end
    end

endmodule

// ----- rtl/core/msitw_checker.sv -----
// Port-level checks for the interval timer core, bound to the top level.
module msitw_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [msitw_pkg::M_DATA_W-1:0]     m_tdata
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed under stall");

    // reset empties the output
    a_rst_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // watchdog trip reports halt with no expirations
    a_fire_halt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[13] |->
            m_tdata[1:0] == msitw_pkg::ST_HALTED && m_tdata[12:5] == '0)
        else $error("watchdog trip without halt status");

    // a failed register claims no slot and expires nothing
    a_noslot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] == msitw_pkg::ST_NOSLOT |->
            m_tdata[4:2] == '0 && m_tdata[12:5] == '0 && !m_tdata[13])
        else $error("no-slot word carries slot or expiry data");

endmodule

bind multi_slot_interval_timer_watchdog_core msitw_checker u_msitw_checker (.*);

// ----- verif/multi_slot_interval_timer_watchdog_core_test.sv -----
// Self-checking testbench for the interval timer core: directed table plus random commands.
`timescale 1ns / 100ps

module multi_slot_interval_timer_watchdog_core_test;

    localparam logic [msitw_pkg::OP_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [msitw_pkg::OP_W-1:0] OP_SPARE_HI = 3'd7;
    localparam int QUIET_LIMIT = 2000;

    typedef struct packed {
        logic [msitw_pkg::TICK_W-1:0]   ticks;
        logic                           fired;
        logic [msitw_pkg::MASK_W-1:0]   mask;
        logic [msitw_pkg::IDX_W-1:0]    idx;
        logic [msitw_pkg::STATUS_W-1:0] status;
    } timer_result_t;

    typedef struct packed {
        logic [msitw_pkg::OP_W-1:0]   op;
        logic [msitw_pkg::SLOT_W-1:0] sl;
        logic [msitw_pkg::IVAL_W-1:0] iv;
        logic                         typed;
        timer_result_t                want;
    } command_row_t;

    localparam logic [$bits(timer_result_t):0] PREDICTED = '0;

    logic                             aclk;
    logic                             aresetn   = 1'b0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [msitw_pkg::S_DATA_W-1:0]   s_tdata   = '0;
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [msitw_pkg::M_DATA_W-1:0]   m_tdata;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [msitw_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [msitw_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // predictor state
    logic [msitw_pkg::SLOTS-1:0]     slot_busy;
    msitw_pkg::count_t               slot_period [msitw_pkg::SLOTS];
    msitw_pkg::count_t               slot_elapsed [msitw_pkg::SLOTS];
    logic [31:0]                     wd_count;
    logic [msitw_pkg::TICK_W-1:0]    ticks;
    logic                            stopped;
    logic                            wd_en;
    logic [msitw_pkg::LIMIT_W-1:0]   wd_lim;

    timer_result_t results_due [$];
    command_row_t  directed_rows [25];
    int            mismatches = 0;
    int            quiet = 0;
    bit            steady = 1'b0;

    multi_slot_interval_timer_watchdog_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic timer_result_t advance_timer(logic [msitw_pkg::OP_W-1:0] op,
                                                    logic [msitw_pkg::SLOT_W-1:0] sl,
                                                    logic [msitw_pkg::IVAL_W-1:0] iv);
        timer_result_t r;
        r = '0;
        if (stopped) begin
            r.status = msitw_pkg::ST_HALTED;
        end else begin
            case (op)
                msitw_pkg::OP_TICK: begin
                    if (wd_en) begin
                        wd_count = wd_count + 1;
                        if (wd_count > {16'd0, wd_lim}) begin
                            stopped  = 1'b1;
                            r.status = msitw_pkg::ST_HALTED;
                            r.fired  = 1'b1;
                        end
                    end
                    if (!stopped) begin
                        ticks = ticks + 1;
                        for (int i = 0; i < msitw_pkg::SLOTS; i++) begin
                            if (slot_busy[i]) begin
                                slot_elapsed[i] = slot_elapsed[i] + 1;
                                if (slot_elapsed[i] >= slot_period[i]) begin
                                    r.mask[i]       = 1'b1;
                                    slot_elapsed[i] = '0;
                                end
                            end
                        end
                    end
                end
                msitw_pkg::OP_REG: begin
                    r.status = msitw_pkg::ST_NOSLOT;
                    for (int i = 0; i < msitw_pkg::SLOTS; i++) begin
                        if (!slot_busy[i]) begin
                            slot_busy[i]    = 1'b1;
                            slot_period[i]  = iv;
                            slot_elapsed[i] = '0;
                            r.status        = msitw_pkg::ST_OK;
                            r.idx           = msitw_pkg::IDX_W'(i);
                            break;
                        end
                    end
                end
                msitw_pkg::OP_UNREG: begin
                    slot_busy[sl] = 1'b0;
                end
                msitw_pkg::OP_REARM: begin
                    if (slot_busy[sl]) begin
                        if (iv == '0) slot_busy[sl] = 1'b0;
                        else slot_period[sl] = iv;
                    end
                end
                msitw_pkg::OP_KICK: begin
                    wd_count = '0;
                end
                default: ;
            endcase
        end
        r.ticks = ticks;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    task automatic issue_command(logic [msitw_pkg::OP_W-1:0] op,
                                 logic [msitw_pkg::SLOT_W-1:0] sl,
                                 logic [msitw_pkg::IVAL_W-1:0] iv,
                                 logic typed, timer_result_t want);
        timer_result_t predicted;
        while (!steady && $urandom_range(0, 99) < 16) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, iv, sl, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = advance_timer(op, sl, iv);
        results_due.push_back(typed ? want : predicted);
    endtask

    task automatic issue_random_commands(int n);
        logic [msitw_pkg::OP_W-1:0]   op;
        logic [msitw_pkg::SLOT_W-1:0] sl;
        logic [msitw_pkg::IVAL_W-1:0] iv;
        int                           pick;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) op = msitw_pkg::OP_TICK;
            else if (pick < 62) op = msitw_pkg::OP_REG;
            else if (pick < 72) op = msitw_pkg::OP_UNREG;
            else if (pick < 87) op = msitw_pkg::OP_REARM;
            else if (pick < 95) op = msitw_pkg::OP_KICK;
            else op = msitw_pkg::OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
            sl   = msitw_pkg::SLOT_W'($urandom_range(0, msitw_pkg::SLOTS - 1));
            pick = $urandom_range(0, 99);
            if (pick < 10) iv = '0;
            else if (pick < 15) iv = $urandom;
            else if (pick < 18) iv = '1;
            else iv = $urandom_range(1, 12);
            issue_command(op, sl, iv, 1'b0, '0);
        end
    endtask

    task automatic drain_results;
        s_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic program_watchdog(logic [msitw_pkg::CFG_DATA_W-1:0] en_word,
                                    logic [msitw_pkg::CFG_DATA_W-1:0] lim);
        cfg_valid <= 1'b1;
        cfg_index <= msitw_pkg::CFG_WD_ENABLE;
        cfg_data  <= en_word;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        wd_en = en_word[0];
        cfg_index <= msitw_pkg::CFG_WD_LIMIT;
        cfg_data  <= lim;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        wd_lim = lim;
        cfg_valid <= 1'b0;
    endtask

    // result side: random backpressure and checking
    always @(posedge aclk) begin
        timer_result_t got;
        timer_result_t want;
        m_tready <= steady || ($urandom_range(0, 99) >= 16);
        if (aresetn && m_tvalid && m_tready) begin
            got = timer_result_t'(m_tdata[$bits(timer_result_t)-1:0]);
            if (results_due.size() == 0) begin
                mismatches++;
                $display("%0t: result word with none expected, actual %0h", $time, got);
            end else begin
                want = results_due.pop_front();
                check_field("status", 32'(want.status), 32'(got.status));
                check_field("slot_index", 32'(want.idx), 32'(got.idx));
                check_field("expired_mask", 32'(want.mask), 32'(got.mask));
                check_field("watchdog_fired", 32'(want.fired), 32'(got.fired));
                check_field("tick_count", want.ticks, got.ticks);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet == QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        slot_busy = '0;
        for (int i = 0; i < msitw_pkg::SLOTS; i++) begin
            slot_period[i]  = '0;
            slot_elapsed[i] = '0;
        end
        wd_count = '0;
        ticks    = '0;
        stopped  = 1'b0;
        wd_en    = 1'b0;
        wd_lim   = msitw_pkg::WD_LIMIT_RST;

        // fields: op, slot, interval, typed, then ticks/fired/mask/idx/status when typed
        directed_rows[0]  = {msitw_pkg::OP_TICK, 3'd0, 32'd0, 1'b1, 32'd1, 1'b0, 8'd0, 3'd0,
                             msitw_pkg::ST_OK};
        directed_rows[1]  = {msitw_pkg::OP_REG, 3'd0, 32'd0, 1'b1, 32'd1, 1'b0, 8'd0, 3'd0,
                             msitw_pkg::ST_OK};
        directed_rows[2]  = {msitw_pkg::OP_REG, 3'd5, 32'hFFFF_FFFF, 1'b1, 32'd1, 1'b0, 8'd0,
                             3'd1, msitw_pkg::ST_OK};
        directed_rows[3]  = {msitw_pkg::OP_REG, 3'd0, 32'd3, PREDICTED};
        directed_rows[4]  = {msitw_pkg::OP_REG, 3'd0, 32'd1, PREDICTED};
        directed_rows[5]  = {msitw_pkg::OP_TICK, 3'd0, 32'd0, PREDICTED};
        directed_rows[6]  = {msitw_pkg::OP_TICK, 3'd0, 32'd0, PREDICTED};
        directed_rows[7]  = {msitw_pkg::OP_TICK, 3'd0, 32'd0, PREDICTED};
        directed_rows[8]  = {msitw_pkg::OP_REARM, 3'd2, 32'd2, PREDICTED};
        directed_rows[9]  = {msitw_pkg::OP_REARM, 3'd0, 32'd0, PREDICTED};
        directed_rows[10] = {msitw_pkg::OP_REARM, 3'd0, 32'd5, PREDICTED};
        directed_rows[11] = {msitw_pkg::OP_UNREG, 3'd3, 32'd0, PREDICTED};
        directed_rows[12] = {msitw_pkg::OP_KICK, 3'd0, 32'd0, PREDICTED};
        directed_rows[13] = {OP_SPARE_LO, 3'd2, 32'd123, PREDICTED};
        directed_rows[14] = {OP_SPARE_HI, 3'd7, 32'hFFFF_FFFF, PREDICTED};
        directed_rows[15] = {msitw_pkg::OP_REG, 3'd0, 32'd7, PREDICTED};
        directed_rows[16] = {msitw_pkg::OP_REG, 3'd0, 32'd9, PREDICTED};
        directed_rows[17] = {msitw_pkg::OP_REG, 3'd0, 32'h8000_0000, PREDICTED};
        directed_rows[18] = {msitw_pkg::OP_REG, 3'd0, 32'd2, PREDICTED};
        directed_rows[19] = {msitw_pkg::OP_REG, 3'd0, 32'd4, PREDICTED};
        directed_rows[20] = {msitw_pkg::OP_REG, 3'd0, 32'd6, PREDICTED};
        directed_rows[21] = {msitw_pkg::OP_REG, 3'd0, 32'd1, 1'b1, 32'd4, 1'b0, 8'd0, 3'd0,
                             msitw_pkg::ST_NOSLOT};
        directed_rows[22] = {msitw_pkg::OP_TICK, 3'd0, 32'd0, PREDICTED};
        directed_rows[23] = {msitw_pkg::OP_UNREG, 3'd7, 32'd0, PREDICTED};
        directed_rows[24] = {msitw_pkg::OP_REARM, 3'd7, 32'd0, PREDICTED};

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // enable takes bit 0 only
        program_watchdog(16'hFFFE, msitw_pkg::WD_LIMIT_RST);
        foreach (directed_rows[i])
            issue_command(directed_rows[i].op, directed_rows[i].sl, directed_rows[i].iv,
                          directed_rows[i].typed, directed_rows[i].want);
        drain_results();

        program_watchdog(16'd1, 16'hFFFF);
        issue_random_commands(200);
        drain_results();
        issue_random_commands(200);
        drain_results();

        // no idling, watchdog count must hold
        steady = 1'b1;
        program_watchdog(16'd0, 16'd0);
        issue_random_commands(350);
        drain_results();
        steady = 1'b0;

        program_watchdog(16'd1, 16'($urandom_range(30, 80)));
        issue_command(msitw_pkg::OP_KICK, 3'd0, 32'd0, 1'b0, '0);
        issue_random_commands(250);
        drain_results();

        // first tick trips the watchdog, the halt then sticks
        program_watchdog(16'd1, 16'd0);
        issue_random_commands(40);
        drain_results();
        program_watchdog(16'd0, 16'hFFFF);
        issue_random_commands(20);
        drain_results();

        if (mismatches == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

endmodule
